// File: rtl/tte_pkg.sv
// Shared types, constants and the microcode table of the tap tempo estimator.
// No dependencies; every rtl module refers to it by scoped names.
package tte_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_W      = 16;
	localparam int CLK_W      = 8;
	localparam int RATE_W     = 8 + FRAC_BITS;
	localparam int DIVD_W     = CFG_W + FRAC_BITS;
	localparam int SUM_W      = RATE_W + 3;
	localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam int ITER_W     = $clog2(DIVD_W);
	localparam int PC_W       = 4;

	// divide by five as multiply by ceil(2^AVG_SHIFT / 5), exact for any SUM_W-bit sum
	localparam int AVG_DIV    = 5;
	localparam int AVG_SHIFT  = SUM_W + 3;
	localparam int RECIP_W    = SUM_W + 1;
	localparam int PROD_W     = SUM_W + RECIP_W;

	localparam logic [RATE_W-1:0] RATE_MAX    = {RATE_W{1'b1}};
	localparam logic [CFG_W-1:0]  RST_TPS     = CFG_W'(12000);
	localparam logic [CFG_W-1:0]  RST_MIN     = CFG_W'(343);
	localparam logic [CFG_W-1:0]  RST_MAX     = CFG_W'(36036);
	localparam logic [CLK_W-1:0]  RST_CLOCK   = CLK_W'(80);
	localparam logic [RECIP_W-1:0] AVG_RECIP  =
		RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DIV - 1)) / 64'(AVG_DIV));

	// configuration register indexes
	localparam logic [1:0] REG_TPS = 2'd0;
	localparam logic [1:0] REG_MIN = 2'd1;
	localparam logic [1:0] REG_MAX = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_TICK,
		OP_LOAD_RATE,
		OP_DIV_STEP,
		OP_TAKE_M,
		OP_LOAD_AVG,
		OP_SET_AVG,
		OP_SET_FIRST,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_NO_MEAS,
		C_DIV_MORE,
		C_FIRST,
		C_OUT_BLOCKED
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic meas;
		logic averaging;
		logic out_blocked;
	} dp_stat_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// step addresses used as jump targets
	localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(0);
	localparam logic [PC_W-1:0] PC_RATE_LOOP = PC_W'(3);
	localparam logic [PC_W-1:0] PC_FIRST     = PC_W'(8);
	localparam logic [PC_W-1:0] PC_EMIT      = PC_W'(9);

	// microprogram: jump to target when cond holds, else fall through
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t uw;
		uw = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
		unique case (pc)
			PC_W'(0):  uw = '{op: OP_ACCEPT,    cond: C_NO_INPUT,    target: PC_IDLE};
			PC_W'(1):  uw = '{op: OP_TICK,      cond: C_NO_MEAS,     target: PC_EMIT};
			PC_W'(2):  uw = '{op: OP_LOAD_RATE, cond: C_NEVER,       target: PC_IDLE};
			PC_W'(3):  uw = '{op: OP_DIV_STEP,  cond: C_DIV_MORE,    target: PC_RATE_LOOP};
			PC_W'(4):  uw = '{op: OP_TAKE_M,    cond: C_FIRST,       target: PC_FIRST};
			PC_W'(5):  uw = '{op: OP_LOAD_AVG,  cond: C_NEVER,       target: PC_IDLE};
			PC_W'(6):  uw = '{op: OP_SET_AVG,   cond: C_ALWAYS,      target: PC_EMIT};
			PC_W'(8):  uw = '{op: OP_SET_FIRST, cond: C_NEVER,       target: PC_IDLE};
			PC_W'(9):  uw = '{op: OP_EMIT,      cond: C_OUT_BLOCKED, target: PC_EMIT};
			PC_W'(10): uw = '{op: OP_NOP,       cond: C_ALWAYS,      target: PC_IDLE};
			default:   uw = '{op: OP_NOP,       cond: C_ALWAYS,      target: PC_IDLE};
		endcase
		return uw;
	endfunction

endpackage

// File: rtl/tte_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tte_pkg.
module tte_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tte_pkg::div_ctl_t                   ctl,
	input  logic [tte_pkg::DIVD_W-1:0]          dvd_in,
	input  logic [tte_pkg::COUNT_BITS-1:0]      dsr_in,
	output logic [tte_pkg::DIVD_W-1:0]          quot,
	output logic                                more
);

	logic [tte_pkg::DIVD_W-1:0]     dvd_q;
	logic [tte_pkg::COUNT_BITS-1:0] dsr_q;
	logic [tte_pkg::COUNT_BITS-1:0] rem_q;
	logic [tte_pkg::ITER_W-1:0]     iter_q;
	logic [tte_pkg::COUNT_BITS:0]   rem_sh;
	logic [tte_pkg::COUNT_BITS:0]   rem_diff;
	logic                           ge;

	assign rem_sh   = {rem_q, dvd_q[tte_pkg::DIVD_W-1]};
	assign rem_diff = rem_sh - {1'b0, dsr_q};
	assign ge       = rem_sh >= {1'b0, dsr_q};
	assign quot     = dvd_q;
	assign more     = iter_q != tte_pkg::ITER_W'(tte_pkg::DIVD_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (ctl.load) begin
			iter_q <= '0;
		end else if (ctl.step) begin
			iter_q <= iter_q + tte_pkg::ITER_W'(1);
		end
	end

	// dividend register shifts out the numerator and fills with quotient bits
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q <= dvd_in;
			dsr_q <= dsr_in;
			rem_q <= '0;
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[tte_pkg::DIVD_W-2:0], ge};
			rem_q <= ge ? rem_diff[tte_pkg::COUNT_BITS-1:0]
				: rem_sh[tte_pkg::COUNT_BITS-1:0];
		end
	end

	a_load_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> dsr_in != '0)
		else $error("divider loaded with zero divisor");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.load && ctl.step))
		else $error("divider load and step together");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.step) |-> rem_q < dsr_q)
		else $error("divider remainder not below divisor");

endmodule

// File: rtl/tte_seq.sv
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on tte_pkg (program table and types).
module tte_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tte_pkg::dp_stat_t stat,
	input  logic              div_more,
	output tte_pkg::op_t      op
);

	logic [tte_pkg::PC_W-1:0] pc_q;
	tte_pkg::uword_t          uw;
	logic                     take;

	assign uw = tte_pkg::ucode(pc_q);
	assign op = uw.op;

	always_comb begin
		unique case (uw.cond)
			tte_pkg::C_NEVER:       take = 1'b0;
			tte_pkg::C_ALWAYS:      take = 1'b1;
			tte_pkg::C_NO_INPUT:    take = !in_valid;
			tte_pkg::C_NO_MEAS:     take = !stat.meas;
			tte_pkg::C_DIV_MORE:    take = div_more;
			tte_pkg::C_FIRST:       take = !stat.averaging;
			tte_pkg::C_OUT_BLOCKED: take = stat.out_blocked;
			default:                take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tte_pkg::PC_IDLE;
		end else begin
			pc_q <= take ? uw.target : pc_q + tte_pkg::PC_W'(1);
		end
	end

	a_accept_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(op == tte_pkg::OP_ACCEPT && in_valid) |=> op == tte_pkg::OP_TICK)
		else $error("accepted tick not followed by counter step");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(op == tte_pkg::OP_EMIT && !stat.out_blocked) |=> op == tte_pkg::OP_NOP)
		else $error("emit step did not retire");

	a_loop_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(op == tte_pkg::OP_DIV_STEP && !div_more) |=>
			(op == tte_pkg::OP_TAKE_M || op == tte_pkg::OP_SET_AVG))
		else $error("divide loop exit went astray");

endmodule

// File: rtl/tte_dp.sv
// Datapath: configuration, tracking state, estimate, averaging and output register.
// Depends on tte_pkg; drives the shared divider through div_ctl_t.
module tte_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tte_pkg::op_t                      op,
	input  logic                              cfg_valid,
	input  logic [1:0]                        cfg_index,
	input  logic [tte_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	input  logic                              tap,
	input  logic                              out_stall,
	input  logic [tte_pkg::DIVD_W-1:0]        quot,
	output tte_pkg::div_ctl_t                 div_ctl,
	output logic [tte_pkg::DIVD_W-1:0]        dvd_in,
	output logic [tte_pkg::COUNT_BITS-1:0]    dsr_in,
	output tte_pkg::dp_stat_t                 stat,
	output logic                              in_stall,
	output logic                              out_valid,
	output logic [tte_pkg::RATE_W-1:0]        rate_estimate,
	output logic [tte_pkg::CLK_W-1:0]         clock_value,
	output logic                              tracking,
	output logic                              updated
);

	localparam int CB = tte_pkg::COUNT_BITS;
	localparam int RW = tte_pkg::RATE_W;

	logic [tte_pkg::CFG_W-1:0] tps_q, min_q, max_q;
	logic                      trk_q, avg_q, meas_q, tap_q, oval_q;
	logic [CB-1:0]             cnt_q, dcnt_q, cnt_inc;
	logic [RW-1:0]             est_q, m_q, m_sat, est_d;
	logic [tte_pkg::CLK_W-1:0] clk_q;
	logic [tte_pkg::SUM_W-1:0] avg_sum, sum_q;
	logic [tte_pkg::PROD_W-1:0] avg_prod;
	logic                      meas_now, hit_max, out_take, set_est;

	assign cnt_inc  = cnt_q + CB'(1);
	assign meas_now = tap_q && (tte_pkg::CMP_W'(cnt_inc) > tte_pkg::CMP_W'(min_q));
	assign hit_max  = tte_pkg::CMP_W'(cnt_inc) == tte_pkg::CMP_W'(max_q);

	assign m_sat = (|quot[tte_pkg::DIVD_W-1:RW]) ? tte_pkg::RATE_MAX : quot[RW-1:0];

	// 3*old + 2*new + 2, rounded by the later divide by five
	assign avg_sum = tte_pkg::SUM_W'(est_q) + tte_pkg::SUM_W'({est_q, 1'b0})
		+ tte_pkg::SUM_W'({m_q, 1'b0}) + tte_pkg::SUM_W'(2);

	assign avg_prod = tte_pkg::PROD_W'(sum_q) * tte_pkg::PROD_W'(tte_pkg::AVG_RECIP);

	assign est_d   = (op == tte_pkg::OP_SET_AVG) ? avg_prod[tte_pkg::AVG_SHIFT +: RW] : m_q;
	assign set_est = (op == tte_pkg::OP_SET_AVG) || (op == tte_pkg::OP_SET_FIRST);

	always_comb begin
		div_ctl.load = 1'b0;
		div_ctl.step = 1'b0;
		dvd_in       = '0;
		dsr_in       = dcnt_q;
		case (op)
			tte_pkg::OP_LOAD_RATE: begin
				div_ctl.load = 1'b1;
				dvd_in       = {tps_q, tte_pkg::FRAC_BITS'(0)};
			end
			tte_pkg::OP_DIV_STEP: div_ctl.step = 1'b1;
			default: ;
		endcase
	end

	assign out_take         = oval_q && !out_stall;
	assign stat.meas        = trk_q && meas_now;
	assign stat.averaging   = avg_q;
	assign stat.out_blocked = oval_q && out_stall;
	assign in_stall         = op != tte_pkg::OP_ACCEPT;
	assign out_valid        = oval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= tte_pkg::RST_TPS;
			min_q <= tte_pkg::RST_MIN;
			max_q <= tte_pkg::RST_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				tte_pkg::REG_TPS: tps_q <= cfg_data;
				tte_pkg::REG_MIN: min_q <= cfg_data;
				tte_pkg::REG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q  <= 1'b0;
			avg_q  <= 1'b0;
			meas_q <= 1'b0;
			cnt_q  <= '0;
			est_q  <= '0;
			clk_q  <= tte_pkg::RST_CLOCK;
			oval_q <= 1'b0;
		end else begin
			if (op == tte_pkg::OP_TICK) begin
				meas_q <= trk_q && meas_now;
				if (trk_q) begin
					if (meas_now) begin
						cnt_q <= '0;
					end else if (hit_max) begin
						cnt_q <= '0;
						trk_q <= 1'b0;
						avg_q <= 1'b0;
					end else begin
						cnt_q <= cnt_inc;
					end
				end else if (tap_q) begin
					trk_q <= 1'b1;
				end
			end
			if (set_est) begin
				est_q <= est_d;
				clk_q <= est_d[RW-1 -: tte_pkg::CLK_W];
			end
			if (op == tte_pkg::OP_SET_FIRST) begin
				avg_q <= 1'b1;
			end
			if (op == tte_pkg::OP_EMIT && !(oval_q && out_stall)) begin
				oval_q <= 1'b1;
			end else if (out_take) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op == tte_pkg::OP_ACCEPT && in_valid) begin
			tap_q <= tap;
		end
		if (op == tte_pkg::OP_TICK) begin
			dcnt_q <= cnt_inc;
		end
		if (op == tte_pkg::OP_TAKE_M) begin
			m_q <= m_sat;
		end
		if (op == tte_pkg::OP_LOAD_AVG) begin
			sum_q <= avg_sum;
		end
		if (op == tte_pkg::OP_EMIT && !(oval_q && out_stall)) begin
			rate_estimate <= est_q;
			clock_value   <= clk_q;
			tracking      <= trk_q;
			updated       <= meas_q;
		end
	end

	a_upd_trk: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && updated) |-> tracking)
		else $error("measurement reported while not tracking");

	a_clk_match: assert property (@(posedge clk) disable iff (!arst_n)
		avg_q |-> clk_q == est_q[RW-1 -: tte_pkg::CLK_W])
		else $error("clock value out of step with estimate");

	a_avg_trk: assert property (@(posedge clk) disable iff (!arst_n)
		avg_q |-> trk_q)
		else $error("averaging without tracking");

endmodule

// File: rtl/tap_tempo_estimator.sv
// Top level of the tap tempo estimator: sequencer, datapath and shared divider.
// Depends on tte_pkg, tte_seq, tte_dp, tte_div.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid / in_stall    | tap
//   out      | out_valid / out_stall  | rate_estimate, clock_value, tracking, updated
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One tick at a time. A tick without a measurement goes from accept through the
// counter step to emit; a measurement also runs the rate divider, which yields
// one quotient bit per cycle, then sets the first estimate or the average. The
// divide by five of the average is a reciprocal multiply of the stored sum. A new
// tick is taken while the previous result still waits in the output register;
// the sequencer holds at its emit step while out_stall keeps that register full.
// Reset restores default configuration and clock value, clears tracking and estimate.
module tap_tempo_estimator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [tte_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              tap,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tte_pkg::RATE_W-1:0]        rate_estimate,
	output logic [tte_pkg::CLK_W-1:0]         clock_value,
	output logic                              tracking,
	output logic                              updated
);

	tte_pkg::op_t                   op;
	tte_pkg::dp_stat_t              stat;
	tte_pkg::div_ctl_t              div_ctl;
	logic [tte_pkg::DIVD_W-1:0]     dvd_in;
	logic [tte_pkg::DIVD_W-1:0]     quot;
	logic [tte_pkg::COUNT_BITS-1:0] dsr_in;
	logic                           div_more;

	assign cfg_ready = 1'b1;

	tte_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.div_more (div_more),
		.op       (op)
	);

	tte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.dvd_in (dvd_in),
		.dsr_in (dsr_in),
		.quot   (quot),
		.more   (div_more)
	);

	tte_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.tap           (tap),
		.out_stall     (out_stall),
		.quot          (quot),
		.div_ctl       (div_ctl),
		.dvd_in        (dvd_in),
		.dsr_in        (dsr_in),
		.stat          (stat),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.rate_estimate (rate_estimate),
		.clock_value   (clock_value),
		.tracking      (tracking),
		.updated       (updated)
	);

endmodule

// File: verif/tap_tempo_estimator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tap_tempo_estimator: tap stream stimulus, tempo predictor, checks.
// Depends on tte_pkg and the rtl top level; needs no files or arguments.
module tap_tempo_estimator_tb;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int         SHOW_MAX   = 50;

	typedef struct packed {
		logic [tte_pkg::RATE_W-1:0] rate;
		logic [tte_pkg::CLK_W-1:0]  clk_val;
		logic                       trk;
		logic                       upd;
	} tick_result_t;

	// Tempo predictor plus the store of predicted per-tick results.
	class tempo_tracker;
		logic [tte_pkg::CFG_W-1:0]      tps;
		logic [tte_pkg::CFG_W-1:0]      min_iv;
		logic [tte_pkg::CFG_W-1:0]      max_iv;
		logic                           trk;
		logic                           avg;
		logic [tte_pkg::COUNT_BITS-1:0] cnt;
		logic [tte_pkg::RATE_W-1:0]     est;
		logic [tte_pkg::CLK_W-1:0]      clk_reg;
		tick_result_t                   expected_ticks[$];
		int                             mismatches;

		function new();
			tps = tte_pkg::RST_TPS;
			min_iv = tte_pkg::RST_MIN;
			max_iv = tte_pkg::RST_MAX;
			trk = 1'b0;
			avg = 1'b0;
			cnt = '0;
			est = '0;
			clk_reg = tte_pkg::RST_CLOCK;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [tte_pkg::CFG_W-1:0] val);
			case (idx)
				tte_pkg::REG_TPS: tps = val;
				tte_pkg::REG_MIN: min_iv = val;
				tte_pkg::REG_MAX: max_iv = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		function void note_tap(logic t);
			tick_result_t r;
			logic [63:0]  m;
			logic [63:0]  q;
			r.upd = 1'b0;
			if (trk) begin
				cnt = cnt + 1'b1;
				if (t && 64'(cnt) > 64'(min_iv)) begin
					q = (64'(tps) << tte_pkg::FRAC_BITS) / 64'(cnt);
					m = (q > 64'(tte_pkg::RATE_MAX)) ? 64'(tte_pkg::RATE_MAX) : q;
					if (avg) begin
						// 0.6 old + 0.4 new, rounded half up
						q = (3 * 64'(est) + 2 * m + 2) / 5;
					end else begin
						q = m;
						avg = 1'b1;
					end
					if (q > 64'(tte_pkg::RATE_MAX))
						q = 64'(tte_pkg::RATE_MAX);
					est = tte_pkg::RATE_W'(q);
					clk_reg = tte_pkg::CLK_W'(est >> tte_pkg::FRAC_BITS);
					cnt = '0;
					r.upd = 1'b1;
				end else if (64'(cnt) == 64'(max_iv)) begin
					cnt = '0;
					trk = 1'b0;
					avg = 1'b0;
				end
			end else if (t) begin
				trk = 1'b1;
			end
			r.rate = est;
			r.clk_val = clk_reg;
			r.trk = trk;
			expected_ticks.push_back(r);
		endfunction

		task report(string msg);
			if (mismatches < SHOW_MAX)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_tick(tick_result_t got);
			tick_result_t want;
			string        diffs;
			if (expected_ticks.size() == 0) begin
				report($sformatf("unexpected result rate=%h clock=%0d", got.rate, got.clk_val));
			end else begin
				want = expected_ticks.pop_front();
				diffs = "";
				if (got.rate !== want.rate)
					diffs = {diffs, $sformatf(" rate %h/%h", got.rate, want.rate)};
				if (got.clk_val !== want.clk_val)
					diffs = {diffs, $sformatf(" clock %0d/%0d", got.clk_val, want.clk_val)};
				if (got.trk !== want.trk)
					diffs = {diffs, $sformatf(" tracking %b/%b", got.trk, want.trk)};
				if (got.upd !== want.upd)
					diffs = {diffs, $sformatf(" updated %b/%b", got.upd, want.upd)};
				if (diffs != "")
					report({"got/want:", diffs});
			end
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [1:0]                  cfg_index;
	logic [tte_pkg::CFG_W-1:0]   cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic                        tap;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [tte_pkg::RATE_W-1:0]  rate_estimate;
	logic [tte_pkg::CLK_W-1:0]   clock_value;
	logic                        tracking;
	logic                        updated;
	logic                        gaps_on;

	tempo_tracker sb;

	tap_tempo_estimator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.tap           (tap),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.rate_estimate (rate_estimate),
		.clock_value   (clock_value),
		.tracking      (tracking),
		.updated       (updated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(50_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	// result side: check every transfer, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_tick(tick_result_t'{rate: rate_estimate, clk_val: clock_value,
				trk: tracking, upd: updated});
		out_stall <= gaps_on && ($urandom_range(99) < 6);
	end

	// in_valid stays high between back-to-back ticks
	task automatic send_tick(input logic t);
		while (gaps_on && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		tap <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_tap(t);
	endtask

	task automatic send_bits(input logic [15:0] bits, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_tick(bits[i]);
	endtask

	task automatic drain_ticks();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx,
			input logic [tte_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(input logic [tte_pkg::CFG_W-1:0] tps,
			input logic [tte_pkg::CFG_W-1:0] mn, input logic [tte_pkg::CFG_W-1:0] mx);
		write_register(tte_pkg::REG_TPS, tps);
		write_register(tte_pkg::REG_MIN, mn);
		write_register(tte_pkg::REG_MAX, mx);
		cfg_valid <= 1'b0;
	endtask

	// Mostly steady tap intervals with jitter, mixed with early taps, noise and
	// silences long enough to drop tracking. Ends with the counter at zero.
	task automatic run_tempo_phase(input int budget, input logic force_pause);
		int sent;
		int lo;
		int hi;
		int base;
		int k;
		int r;
		int n;
		int mn;
		int mx;
		logic paused;
		sent = 0;
		paused = 1'b0;
		mn = sb.min_iv;
		mx = sb.max_iv;
		lo = mn + 1;
		hi = (mx < mn + 41) ? mx : mn + 41;
		base = (hi >= lo) ? int'($urandom_range(hi, lo)) : 0;
		while (sent < budget) begin
			r = $urandom_range(99);
			if (r < 75 && base > 0) begin
				if (!sb.trk) begin
					send_tick(1'b1);
					sent++;
				end
				k = base + int'($urandom_range(6)) - 3;
				if (k < lo)
					k = lo;
				if (k > mx)
					k = mx;
				for (n = 1; n < k; n++)
					send_tick(1'b0);
				send_tick(1'b1);
				sent += k;
			end else if (r < 85 && mn > 0) begin
				// tap too early to be measured
				k = $urandom_range(mn, 1);
				for (n = 1; n < k; n++)
					send_tick(1'b0);
				send_tick(1'b1);
				sent += k;
			end else if (r < 93 || mx > 200) begin
				n = $urandom_range(20, 1);
				repeat (n)
					send_tick($urandom_range(3) == 0);
				sent += n;
			end else begin
				do begin
					send_tick(1'b0);
					sent++;
				end while (sb.trk);
			end
			if ((force_pause && !paused && sent >= budget / 2) || $urandom_range(99) == 0) begin
				paused = 1'b1;
				drain_ticks();
			end
		end
		while (sb.trk && sb.cnt != 0)
			send_tick(int'(sb.cnt) + 1 > mn);
		drain_ticks();
	endtask

	initial begin
		logic [tte_pkg::CFG_W-1:0] tps;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		tap = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = tte_pkg::REG_TPS;
		cfg_data = '0;
		gaps_on = 1'b1;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: idle tick, first tap, tap below the minimum interval
		send_bits(16'b0110, 4);
		drain_ticks();

		// maximum lowered to a few ticks past the running count: tracking is dropped
		write_register(REG_UNUSED, tte_pkg::CFG_W'($urandom));
		set_config(tte_pkg::CFG_W'($urandom), 16'hFFFF, 16'd5);
		while (sb.trk)
			send_tick($urandom_range(1));
		drain_ticks();

		// saturated rate, saturated average, abandon at a one-tick maximum
		set_config(16'hFFFF, 16'd0, 16'd1);
		send_bits(16'b1110, 4);
		drain_ticks();

		// zero tick rate gives a zero measurement
		set_config(16'd0, 16'd0, 16'd3);
		send_bits(16'b101000, 6);
		drain_ticks();

		set_config(16'd1, 16'd2, 16'hFFFF);
		send_bits(16'b1111001, 7);
		drain_ticks();

		for (int p = 0; p < 8; p++) begin
			gaps_on = (p != 3);
			case ($urandom_range(3))
				0: tps = tte_pkg::CFG_W'($urandom_range(65535, 1));
				1: tps = tte_pkg::CFG_W'($urandom_range(400, 1));
				2: tps = 16'hFFFF;
				default: tps = 16'd1;
			endcase
			if (p == 0)
				set_config(tte_pkg::RST_TPS, tte_pkg::RST_MIN, tte_pkg::RST_MAX);
			else if (p == 1)
				set_config(tps, tte_pkg::CFG_W'($urandom_range(24)), 16'hFFFF);
			else
				set_config(tps, tte_pkg::CFG_W'($urandom_range(24)),
					tte_pkg::CFG_W'($urandom_range(90, 1)));
			run_tempo_phase((p == 0) ? 450 : 90, p == 2);
		end

		gaps_on = 1'b1;
		drain_ticks();
		repeat (100)
			@(posedge clk);
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
